[hdl/sbt_pkg.sv]
`default_nettype none

package sbt_pkg;

   localparam int unsigned MaxBreakpoints = 16;

   localparam int unsigned CmdW      = 2;
   localparam int unsigned AddrW     = 16;
   localparam int unsigned IndexW    = 4;
   localparam int unsigned StatusW   = 3;
   localparam int unsigned CountOutW = 5;
   localparam int unsigned LimitW    = 5;

   localparam logic [LimitW-1:0] LimitReset = LimitW'(16);

   typedef enum logic [CmdW-1:0] {
      CMD_TOGGLE,
      CMD_QUERY,
      CMD_REMOVE,
      CMD_READ
   } cmd_type;

   typedef enum logic [StatusW-1:0] {
      ST_ADDED,
      ST_REMOVED,
      ST_LIMIT,
      ST_FOUND,
      ST_NOT_FOUND,
      ST_BAD_INDEX,
      ST_INDEX_OK
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DEL,
      S_INS,
      S_INS_LAST,
      S_RD,
      S_FIN
   } state_type;

   typedef struct packed {
      status_type             status;
      logic [AddrW-1:0]       entry_address;
      logic [CountOutW-1:0]   entry_count;
   } result_type;

endpackage

`default_nettype wire

[hdl/sbt_if.sv]
`default_nettype none

interface sbt_req_if import sbt_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CmdW-1:0]   cmd;
   logic [AddrW-1:0]  address;
   logic [IndexW-1:0] index;

   modport source (output valid, cmd, address, index, input ready);
   modport sink   (input valid, cmd, address, index, output ready);
endinterface

interface sbt_rsp_if import sbt_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [StatusW-1:0]   status;
   logic [AddrW-1:0]     entry_address;
   logic [CountOutW-1:0] entry_count;

   modport source (output valid, status, entry_address, entry_count, input ready);
   modport sink   (input valid, status, entry_address, entry_count, output ready);
endinterface

interface sbt_csr_if import sbt_pkg::*;;
   logic              valid;
   logic              ready;
   logic [LimitW-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[hdl/sorted_breakpoint_table.sv]
// Sorted breakpoint table: ascending, duplicate-free list of 16-bit addresses.
//
// req_if  : command word (cmd, address, index), taken when valid && ready.
// rsp_if  : one result word per command (status, entry_address, entry_count),
//           held in an output register until the receiver takes it.
// csr_if  : write of breakpoint_limit; always ready, write only while idle.
//
// Steps per command, from acceptance to result in the output register (all
// memory traffic goes through one read and one write port of the entry RAM):
//   query          : linear search, one entry per cycle
//   toggle         : search, shift up, write; search, then shift down when it removes
//   remove at index: shift the entries above the index down; no shift out of range
//   read at index  : one entry read; no read out of range
// One command at a time: the next is accepted in the cycle after the handoff.
// A stalled receiver holds one result in the register and one finished
// result in the sequencer, then the input stalls.
// Reset empties the table (count zero) and sets the limit to 16; no clearing
// pass is needed since only entries below the count are ever read.
`default_nettype none

module sorted_breakpoint_table import sbt_pkg::*; #(
   parameter int unsigned MAX_BREAKPOINTS = MaxBreakpoints
) (
   input wire logic   clock,
   input wire logic   reset,
   sbt_req_if.sink    req_if,
   sbt_rsp_if.source  rsp_if,
   sbt_csr_if.sink    csr_if
);

   localparam int unsigned AW = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;

   // config register
   logic [LimitW-1:0] limit_ff, limit_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   // sequencer result handoff
   logic       res_valid;
   logic       res_ready;
   result_type res;

   // entry RAM ports
   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [AddrW-1:0] mem_wr_data;
   logic [AW-1:0]    mem_rd_addr;
   logic [AddrW-1:0] mem_rd_data;

   assign csr_if.ready = 1'b1;

   // output register takes a new word when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_data_ff.status;
   assign rsp_if.entry_address = rsp_data_ff.entry_address;
   assign rsp_if.entry_count   = rsp_data_ff.entry_count;

   always_comb begin
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (csr_if.valid) begin
         limit_in = csr_if.data;
      end
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LimitReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // search / shift sequencer; reads and writes in a shift never hit the
   // same entry in one cycle, so no forwarding is needed
   sbt_ctrl #(
      .MAX_BREAKPOINTS (MAX_BREAKPOINTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_cmd     (req_if.cmd),
      .req_address (req_if.address),
      .req_index   (req_if.index),
      .limit       (limit_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // entry store, one word per breakpoint
   sbt_ram #(
      .Width (AddrW),
      .Depth (MAX_BREAKPOINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

[hdl/sbt_ram.sv]
`default_nettype none

module sbt_ram #(
   parameter int unsigned Width = 16,
   parameter int unsigned Depth = 16,
   localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [Width-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/sbt_ctrl.sv]
`default_nettype none

module sbt_ctrl import sbt_pkg::*; #(
   parameter int unsigned MAX_BREAKPOINTS = MaxBreakpoints,
   localparam int unsigned AW = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CmdW-1:0]   req_cmd,
   input  wire logic [AddrW-1:0]  req_address,
   input  wire logic [IndexW-1:0] req_index,
   input  wire logic [LimitW-1:0] limit,
   output logic                   res_valid,
   input  wire logic              res_ready,
   output result_type             res,
   output logic                   mem_wr_en,
   output logic [AW-1:0]          mem_wr_addr,
   output logic [AddrW-1:0]       mem_wr_data,
   output logic [AW-1:0]          mem_rd_addr,
   input  wire logic [AddrW-1:0]  mem_rd_data
);

   localparam int unsigned CW  = $clog2(MAX_BREAKPOINTS + 1);
   localparam int unsigned CW1 = CW + 1;
   localparam int unsigned EW  = (CW > LimitW) ? CW : LimitW;
   localparam int unsigned IW  = (CW > IndexW) ? CW : IndexW;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic [CW-1:0]    pos_ff, pos_in;
   logic [CW-1:0]    sh_ff, sh_in;
   logic [CW-1:0]    count_ff, count_in;
   status_type       status_ff, status_in;
   logic [AddrW-1:0] value_ff, value_in;

   logic [EW-1:0]  lim_eff;
   logic           at_limit;
   logic           idx_ok;
   logic           in_range;
   logic           hit;
   logic [CW-1:0]  del_pos;
   logic [CW1-1:0] del_next1;
   logic           del_more;
   logic [CW1-1:0] pos_next1;
   logic [CW1-1:0] sh_next1;

   // effective limit is min(limit, capacity)
   assign lim_eff   = (EW'(limit) > EW'(MAX_BREAKPOINTS)) ? EW'(MAX_BREAKPOINTS) : EW'(limit);
   assign at_limit  = EW'(count_ff) >= lim_eff;
   assign idx_ok    = IW'(req_index) < IW'(count_ff);
   assign in_range  = pos_ff != count_ff;
   assign hit       = in_range && (mem_rd_data == addr_ff);
   assign del_pos   = (state_ff == S_IDLE) ? CW'(req_index) : pos_ff;
   assign del_next1 = CW1'(del_pos) + CW1'(1);
   assign del_more  = del_next1 < CW1'(count_ff);
   assign pos_next1 = CW1'(pos_ff) + CW1'(1);
   assign sh_next1  = CW1'(sh_ff) + CW1'(1);

   assign res.status        = status_ff;
   assign res.entry_address = value_ff;
   assign res.entry_count   = CountOutW'(count_ff);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      addr_in     = addr_ff;
      pos_in      = pos_ff;
      sh_in       = sh_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      value_in    = value_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_addr = '0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = cmd_type'(req_cmd);
               addr_in  = req_address;
               value_in = '0;
               case (cmd_type'(req_cmd))
                  CMD_TOGGLE, CMD_QUERY: begin
                     pos_in      = '0;
                     mem_rd_addr = '0;
                     state_in    = S_SCAN;
                  end
                  CMD_REMOVE: begin
                     if (!idx_ok) begin
                        status_in = ST_BAD_INDEX;
                        state_in  = S_FIN;
                     end else if (del_more) begin
                        mem_rd_addr = AW'(del_next1);
                        sh_in       = CW'(del_next1);
                        state_in    = S_DEL;
                     end else begin
                        count_in  = count_ff - CW'(1);
                        status_in = ST_REMOVED;
                        state_in  = S_FIN;
                     end
                  end
                  CMD_READ: begin
                     if (idx_ok) begin
                        mem_rd_addr = AW'(req_index);
                        status_in   = ST_INDEX_OK;
                        state_in    = S_RD;
                     end else begin
                        status_in = ST_BAD_INDEX;
                        state_in  = S_FIN;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         // one entry per cycle; data for pos_ff arrives this cycle
         S_SCAN: begin
            if (in_range && (mem_rd_data < addr_ff)) begin
               pos_in      = CW'(pos_next1);
               mem_rd_addr = AW'(pos_next1);
            end else if (cmd_ff == CMD_QUERY) begin
               status_in = hit ? ST_FOUND : ST_NOT_FOUND;
               state_in  = S_FIN;
            end else if (hit) begin
               if (del_more) begin
                  mem_rd_addr = AW'(del_next1);
                  sh_in       = CW'(del_next1);
                  state_in    = S_DEL;
               end else begin
                  count_in  = count_ff - CW'(1);
                  status_in = ST_REMOVED;
                  state_in  = S_FIN;
               end
            end else if (at_limit) begin
               status_in = ST_LIMIT;
               state_in  = S_FIN;
            end else if (in_range) begin
               mem_rd_addr = AW'(count_ff - CW'(1));
               sh_in       = count_ff - CW'(1);
               state_in    = S_INS;
            end else begin
               state_in = S_INS_LAST;
            end
         end

         // shift down: entry sh_ff moves to sh_ff-1, read runs one ahead
         S_DEL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(sh_ff - CW'(1));
            mem_wr_data = mem_rd_data;
            if (sh_next1 < CW1'(count_ff)) begin
               mem_rd_addr = AW'(sh_next1);
               sh_in       = CW'(sh_next1);
            end else begin
               count_in  = count_ff - CW'(1);
               status_in = ST_REMOVED;
               state_in  = S_FIN;
            end
         end

         // shift up: entry sh_ff moves to sh_ff+1, read runs one behind
         S_INS: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(sh_next1);
            mem_wr_data = mem_rd_data;
            if (sh_ff != pos_ff) begin
               mem_rd_addr = AW'(sh_ff - CW'(1));
               sh_in       = sh_ff - CW'(1);
            end else begin
               state_in = S_INS_LAST;
            end
         end

         S_INS_LAST: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(pos_ff);
            mem_wr_data = addr_ff;
            count_in    = count_ff + CW'(1);
            status_in   = ST_ADDED;
            state_in    = S_FIN;
         end

         S_RD: begin
            value_in = mem_rd_data;
            state_in = S_FIN;
         end

         S_FIN: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      addr_ff   <= addr_in;
      pos_ff    <= pos_in;
      sh_ff     <= sh_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

endmodule

`default_nettype wire

[hdl/sbt_checker.sv]
`default_nettype none

module sbt_checker import sbt_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [StatusW-1:0] rsp_status,
   input wire logic [AddrW-1:0]   rsp_entry_address
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_entry_address))
      else $error("rsp word changed while stalled");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != StatusW'(ST_INDEX_OK)) |-> rsp_entry_address == '0)
      else $error("entry_address nonzero without a successful read");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind sorted_breakpoint_table sbt_checker u_sbt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_status        (rsp_if.status),
   .rsp_entry_address (rsp_if.entry_address)
);

`default_nettype wire

[verif/breakpoint_checker.sv]
`default_nettype none

module breakpoint_checker import sbt_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   sbt_req_if       req_mon,
   sbt_rsp_if       rsp_mon,
   sbt_csr_if       csr_mon,
   output int       fail_count,
   output int       words_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DueDepth = 8;

   logic [AddrW-1:0]  shadow_addr [MaxBreakpoints];
   int unsigned       shadow_count;
   logic [LimitW-1:0] shadow_limit;
   // results owed by the block, oldest at due_rd
   result_type        due_fifo [DueDepth];
   int unsigned       due_wr;
   int unsigned       due_rd;

   // close the gap left by a deleted entry
   function automatic void drop_entry(int unsigned pos);
      int unsigned i;
      for (i = pos; i + 1 < shadow_count; i++)
         shadow_addr[i] = shadow_addr[i + 1];
      shadow_count--;
   endfunction

   // apply one command word to the shadow table, return the word it should answer
   function automatic result_type apply_command(cmd_type op, logic [AddrW-1:0] addr,
                                                logic [IndexW-1:0] idx);
      result_type  res;
      int unsigned cap;
      int unsigned pos;
      int unsigned i;
      res.status        = ST_NOT_FOUND;
      res.entry_address = '0;
      cap = (shadow_limit > MaxBreakpoints) ? MaxBreakpoints : shadow_limit;
      pos = 0;
      while (pos < shadow_count && shadow_addr[pos] < addr)
         pos++;
      case (op)
         CMD_TOGGLE: begin
            if (pos < shadow_count && shadow_addr[pos] == addr) begin
               drop_entry(pos);
               res.status = ST_REMOVED;
            end else if (shadow_count >= cap) begin
               res.status = ST_LIMIT;
            end else begin
               for (i = shadow_count; i > pos; i--)
                  shadow_addr[i] = shadow_addr[i - 1];
               shadow_addr[pos] = addr;
               shadow_count++;
               res.status = ST_ADDED;
            end
         end
         CMD_QUERY: begin
            res.status = (pos < shadow_count && shadow_addr[pos] == addr) ? ST_FOUND
                                                                         : ST_NOT_FOUND;
         end
         CMD_REMOVE: begin
            if (idx < shadow_count) begin
               drop_entry(idx);
               res.status = ST_REMOVED;
            end else begin
               res.status = ST_BAD_INDEX;
            end
         end
         default: begin
            if (idx < shadow_count) begin
               res.entry_address = shadow_addr[idx];
               res.status        = ST_INDEX_OK;
            end else begin
               res.status = ST_BAD_INDEX;
            end
         end
      endcase
      res.entry_count = CountOutW'(shadow_count);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         shadow_count = 0;
         shadow_limit = LimitReset;
         due_wr       = 0;
         due_rd       = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_wr == due_rd) begin
               $display("%0t: result word with none due: status %0d address %h count %0d",
                        $realtime, rsp_mon.status, rsp_mon.entry_address, rsp_mon.entry_count);
               fail_count++;
            end else begin
               want = due_fifo[due_rd % DueDepth];
               due_rd++;
               if (rsp_mon.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                           rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.entry_address !== want.entry_address) begin
                  $display("%0t: entry_address expected %h actual %h", $realtime,
                           want.entry_address, rsp_mon.entry_address);
                  fail_count++;
               end
               if (rsp_mon.entry_count !== want.entry_count) begin
                  $display("%0t: entry_count expected %0d actual %0d", $realtime,
                           want.entry_count, rsp_mon.entry_count);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (due_wr - due_rd == DueDepth) begin
               $display("%0t: more than %0d result words owed", $realtime, DueDepth);
               fail_count++;
            end else begin
               due_fifo[due_wr % DueDepth] = apply_command(cmd_type'(req_mon.cmd),
                                                           req_mon.address, req_mon.index);
               due_wr++;
            end
         end
         if (csr_mon.valid && csr_mon.ready)
            shadow_limit = csr_mon.data;
      end
      words_pending = int'(due_wr - due_rd);
   end

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb import sbt_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // slowest word: search and shift, plus a long send gap and a long receive
   // stall; ~900 words, then the squeeze, then many times over
   localparam int CycleLimit = 600_000;
   localparam int PhaseWords = 85;
   localparam int PoolSize   = 20;
   localparam int SqueezeLen = 300;

   logic clock;
   logic reset;
   int   fail_count;
   int   words_pending;

   // no gaps on either side while set
   bit   quiet;
   // asks the receive side for one long hold-off
   bit   squeeze_pending;

   logic [AddrW-1:0] addr_pool [PoolSize];

   sbt_req_if req ();
   sbt_rsp_if rsp ();
   sbt_csr_if csr ();

   sorted_breakpoint_table i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   breakpoint_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req),
      .rsp_mon       (rsp),
      .csr_mon       (csr),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one command word. valid stays high on return so a zero gap keeps the
   // next word on the bus without a low cycle (one assignment per step).
   task automatic send_word(cmd_type op, logic [AddrW-1:0] addr, logic [IndexW-1:0] idx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.cmd     <= op;
      req.address <= addr;
      req.index   <= idx;
      do @(posedge clock); while (!req.ready);
   endtask

   // Drop valid and wait until every result word has come back.
   // The extra edge first makes sure the last accepted word is counted.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   // limit write only while the table is idle
   task automatic write_limit(logic [LimitW-1:0] lim);
      drain();
      repeat (4) @(posedge clock);
      csr.valid <= 1'b1;
      csr.data  <= lim;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
   endtask

   // Fresh address pool per phase: a cluster of neighbors (insert/remove in the
   // middle of the table) plus scattered values and, at random, both ends of the range.
   task automatic fill_pool();
      logic [AddrW-1:0] base;
      int k;
      base = AddrW'($urandom);
      for (k = 0; k < PoolSize; k++) begin
         if (k < PoolSize / 2)
            base = base + AddrW'($urandom_range(1, 3));
         addr_pool[k] = (k < PoolSize / 2) ? base : AddrW'($urandom);
      end
      if ($urandom_range(0, 1) == 1)
         addr_pool[0] = '0;
      if ($urandom_range(0, 1) == 1)
         addr_pool[PoolSize - 1] = '1;
   endtask

   // Random word: mostly toggles and queries on the pool so the table really
   // fills, hits the limit and empties again; some wild addresses and indexes.
   task automatic random_word();
      int r;
      logic [IndexW-1:0] idx;
      r   = $urandom_range(0, 99);
      idx = ($urandom_range(0, 2) == 0) ? IndexW'($urandom) : IndexW'($urandom_range(0, 7));
      if (r < 40)
         send_word(CMD_TOGGLE, addr_pool[$urandom_range(0, PoolSize - 1)], idx);
      else if (r < 55)
         send_word(CMD_QUERY, addr_pool[$urandom_range(0, PoolSize - 1)], idx);
      else if (r < 62)
         send_word(CMD_TOGGLE, AddrW'($urandom), idx);
      else if (r < 67)
         send_word(CMD_QUERY, AddrW'($urandom), idx);
      else if (r < 87)
         send_word(CMD_READ, AddrW'($urandom), idx);
      else
         send_word(CMD_REMOVE, AddrW'($urandom), idx);
   endtask

   // Receive side: one ready assignment per edge. Random stalls, plus one long
   // hold-off on request so the result register and the sequencer back up.
   initial begin : receive_side
      int stall;
      stall     = 0;
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_pending) begin
            squeeze_pending = 1'b0;
            stall           = SqueezeLen;
         end
         if (reset) begin
            rsp.ready <= 1'b0;
         end else if (stall > 0) begin
            rsp.ready <= 1'b0;
            stall--;
         end else begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               stall = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      logic [LimitW-1:0] phase_limit [10];
      int p;
      int n;
      reset           = 1'b1;
      quiet           = 1'b0;
      squeeze_pending = 1'b0;
      req.valid       = 1'b0;
      req.cmd         = CMD_TOGGLE;
      req.address     = '0;
      req.index       = '0;
      csr.valid       = 1'b0;
      csr.data        = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, both address extremes, every command, every status
      send_word(CMD_READ,   16'h0000, 4'd0);    // read on empty table
      send_word(CMD_REMOVE, 16'h0000, 4'd15);   // remove on empty table
      send_word(CMD_QUERY,  16'h1234, 4'd0);
      send_word(CMD_TOGGLE, 16'hFFFF, 4'd0);
      send_word(CMD_TOGGLE, 16'h0000, 4'd0);    // insert in front
      send_word(CMD_TOGGLE, 16'h8000, 4'd0);    // insert in the middle
      send_word(CMD_QUERY,  16'h8000, 4'd0);
      send_word(CMD_QUERY,  16'h7FFF, 4'd0);
      send_word(CMD_READ,   16'h0000, 4'd0);
      send_word(CMD_READ,   16'h0000, 4'd2);
      send_word(CMD_READ,   16'h0000, 4'd3);    // index equal to count
      send_word(CMD_REMOVE, 16'h0000, 4'd1);
      send_word(CMD_TOGGLE, 16'hFFFF, 4'd0);    // toggle removes last entry
      send_word(CMD_TOGGLE, 16'h5555, 4'd0);
      send_word(CMD_TOGGLE, 16'hAAAA, 4'd0);

      // limit below count: adds refused, removes still work, entries kept
      write_limit(LimitW'(2));
      send_word(CMD_TOGGLE, 16'h1111, 4'd0);
      send_word(CMD_TOGGLE, 16'h5555, 4'd0);    // present address while over limit
      send_word(CMD_TOGGLE, 16'h1111, 4'd0);    // count at limit
      send_word(CMD_REMOVE, 16'h0000, 4'd0);
      send_word(CMD_TOGGLE, 16'h1111, 4'd0);
      send_word(CMD_READ,   16'h0000, 4'd15);

      write_limit(LimitW'(0));
      send_word(CMD_TOGGLE, 16'h2222, 4'd0);    // zero limit refuses every add
      send_word(CMD_TOGGLE, 16'hAAAA, 4'd0);
      send_word(CMD_REMOVE, 16'h0000, 4'd9);

      // random phases: full range of the limit, above capacity included
      phase_limit = '{LimitW'(16), LimitW'(31), LimitW'(0), LimitW'(1), LimitW'(16),
                      LimitW'(2), LimitW'(20), LimitW'($urandom), LimitW'(15),
                      LimitW'($urandom)};
      for (p = 0; p < 10; p++) begin
         write_limit(phase_limit[p]);
         fill_pool();
         quiet = (p == 4);
         for (n = 0; n < PhaseWords; n++) begin
            if (p == 3 && n == 20)
               squeeze_pending = 1'b1;
            random_word();
         end
      end
      quiet = 1'b0;

      drain();
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
